FILE: rtl/core/dbbc_pkg.sv
// Package for the debounced button blink-code block: types, constants, codes.
package dbbc_pkg;

  // Preset count and the millisecond thresholds of the indicator timing
  localparam int unsigned PRESET_COUNT = 16;
  localparam logic [31:0] HOLD_OFF_MS  = 32'd5000;
  localparam logic [31:0] MIN_PRESS_MS = 32'd100;
  localparam logic [31:0] BLINK_MS     = 32'd200;
  localparam logic [31:0] PAUSE_MS     = 32'd1000;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PRESET_W = 4;
  localparam int unsigned SHOTS_W  = 16;
  localparam int unsigned BLINK_W  = 5;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_OFF_EN = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] AMMO_RESET     = 16'd0;

  // Clamped preset code, as a blink target width
  localparam logic [BLINK_W-1:0] PRESET_MAX = BLINK_W'(PRESET_COUNT - 1);

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] shot_limit;
    logic        hold_power_off_enable;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic                button_pressed;
    logic [PRESET_W-1:0] preset_index;
    logic [SHOTS_W-1:0]  shots_fired;
  } poll_t;

  typedef struct packed {
    logic red_led;
    logic green_led;
    logic toggle_preset;
    logic power_off;
  } result_t;

endpackage

FILE: rtl/core/dbbc_cfg.sv
// Configuration register file of the debounced button blink-code block.
module dbbc_cfg
  import dbbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms           <= DEBOUNCE_RESET;
      cfg_r.shot_limit            <= AMMO_RESET;
      cfg_r.hold_power_off_enable <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE_MS: cfg_r.debounce_ms           <= wr_data;
        REG_SHOT_LIMIT:  cfg_r.shot_limit            <= wr_data;
        REG_HOLD_OFF_EN: cfg_r.hold_power_off_enable <= wr_data[0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/dbbc_step.sv
// Button and indicator state with the single-pass update for one poll.
module dbbc_step
  import dbbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  poll_t   poll,
  input  cfg_t    cfg,
  output result_t result
);

  logic               held_r,  held_nxt;
  logic [TIME_W-1:0]  lbt_r,   lbt_nxt;
  logic [TIME_W-1:0]  ind_r,   ind_nxt;
  logic [BLINK_W-1:0] bd_r,    bd_nxt;
  logic               lit_r,   lit_nxt;
  logic               red_r,   red_nxt;
  logic               green_r, green_nxt;

  logic [TIME_W-1:0]  d_btn, d_ind;
  logic [BLINK_W-1:0] preset_w, target;
  logic past_db, press, power, release_ev, toggle, blink_on, blink_off, pause_clr;
  logic ammo_out;

  // Time differences against the stored button and indicator times
  assign d_btn   = poll.now_ms - lbt_r;
  assign d_ind   = poll.now_ms - ind_r;
  assign past_db = d_btn > {16'd0, cfg.debounce_ms};

  // Blink target: clamped preset plus one
  assign preset_w = {1'b0, poll.preset_index};
  assign target   = ((preset_w > PRESET_MAX) ? PRESET_MAX : preset_w) + BLINK_W'(1);

  // Button events; a fresh press leaves a zero hold time, so the stored
  // held flag and time decide power-off and release
  assign press      = !held_r && poll.button_pressed && past_db;
  assign power      = cfg.hold_power_off_enable && held_r && poll.button_pressed &&
                      past_db && (d_btn > HOLD_OFF_MS);
  assign release_ev = !power && held_r && !poll.button_pressed && past_db;
  assign toggle     = release_ev && (d_btn > MIN_PRESS_MS);

  // Indicator steps; a toggle restarts the code at this poll's time
  assign blink_on  = !power && !toggle && !lit_r && (d_ind > BLINK_MS) && (bd_r < target);
  assign blink_off = !power && !toggle && lit_r && (d_ind > BLINK_MS);
  assign pause_clr = !power && !toggle && !lit_r && (d_ind > PAUSE_MS) && (bd_r >= target);
  assign ammo_out  = (cfg.shot_limit != 16'd0) && (poll.shots_fired >= cfg.shot_limit);

  // Next state, in the order of the poll's steps
  always_comb begin
    held_nxt  = held_r;
    lbt_nxt   = lbt_r;
    ind_nxt   = ind_r;
    bd_nxt    = bd_r;
    lit_nxt   = lit_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    if (press) begin
      held_nxt  = 1'b1;
      red_nxt   = 1'b1;
      green_nxt = 1'b0;
      lbt_nxt   = poll.now_ms;
    end
    if (release_ev) begin
      held_nxt = 1'b0;
      lbt_nxt  = poll.now_ms;
      red_nxt  = 1'b0;
    end
    if (toggle) begin
      bd_nxt  = '0;
      lit_nxt = 1'b0;
      ind_nxt = poll.now_ms;
    end
    if (blink_on) begin
      if (ammo_out) begin
        red_nxt = 1'b1;
      end else begin
        green_nxt = 1'b1;
      end
      lit_nxt = 1'b1;
      ind_nxt = poll.now_ms;
      bd_nxt  = bd_r + BLINK_W'(1);
    end
    if (blink_off) begin
      red_nxt   = 1'b0;
      green_nxt = 1'b0;
      lit_nxt   = 1'b0;
      ind_nxt   = poll.now_ms;
    end
    if (pause_clr) begin
      bd_nxt = '0;
    end
  end

  // State registers, updated once per poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      lbt_r   <= '0;
      ind_r   <= '0;
      bd_r    <= '0;
      lit_r   <= 1'b0;
      red_r   <= 1'b0;
      green_r <= 1'b0;
    end else if (fire) begin
      held_r  <= held_nxt;
      lbt_r   <= lbt_nxt;
      ind_r   <= ind_nxt;
      bd_r    <= bd_nxt;
      lit_r   <= lit_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
    end
  end

  assign result.red_led       = red_nxt;
  assign result.green_led     = green_nxt;
  assign result.toggle_preset = toggle;
  assign result.power_off     = power;

endmodule

FILE: rtl/core/debounced_button_blink_code_top.sv
// Top level of the debounced button blink-code block: stream ports and pipeline.
// Path: a taken poll goes to the input register, and its result to the result register
// once the output is free; a stalled output holds both registers.
// Throughput: one poll per cycle unless out_tready stalls the output; the state
// update is one pass of compares from the input register to state and result registers.
// Reset (rst_n low, synchronous): state cleared, registers at their reset values,
// both pipeline stages empty.
module debounced_button_blink_code_top
  import dbbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] now_ms, [32] button_pressed, [36:33] preset_index, [52:37] shots_fired
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] red_led, [1] green_led, [2] toggle_preset, [3] power_off
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  poll_t   poll_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t res_r;
  result_t step_res;
  logic    out_free, s1_move, in_take;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  dbbc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      poll_r.now_ms         <= in_tdata[31:0];
      poll_r.button_pressed <= in_tdata[32];
      poll_r.preset_index   <= in_tdata[36:33];
      poll_r.shots_fired    <= in_tdata[52:37];
    end
  end

  dbbc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_move),
    .poll   (poll_r),
    .cfg    (cfg),
    .result (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.power_off, res_r.toggle_preset,
                       res_r.green_led, res_r.red_led};

endmodule
